// File: hw/rtl/port_proto_rule_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the port and protocol rule table
// Shared immediate-implication and next-cycle forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef PORT_PROTO_RULE_TABLE_UNIT_MACROS_SVH
`define PORT_PROTO_RULE_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pprt_pkg.sv
// ----------------------------------------------------------------------------
// Rule table package
// Sizes, operation and status codes, and the controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pprt_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int TARGET_BITS = 32;

	localparam int PORT_W  = 16;
	localparam int PROTO_W = 2;
	localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
	localparam int ENTRY_W = PORT_W + PROTO_W + TARGET_BITS;

	// External field widths.
	localparam int MODE_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int TGT_IO_W     = 32;
	localparam int HIT_SLOT_W   = 4;
	localparam int RULE_COUNT_W = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_FIND  = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	typedef struct packed {
		logic load_item;
		logic clear;
		logic scan_rst;
		logic scan_en;
		logic write;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic is_add;
		logic match;
		logic free;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/pprt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/pprt_ctrl.sv
// ----------------------------------------------------------------------------
// Rule table controller
// Sequences the accept, slot scan, decision, write and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "port_proto_rule_table_unit_macros.svh"

module pprt_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [pprt_pkg::MODE_W-1:0]         in_mode,
	output logic                                in_ready,
	input  pprt_pkg::sts_t                      sts,
	output pprt_pkg::cmd_t                      cmd
);

	import pprt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_DECIDE = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.scan_rst  = 1'b1;
					unique case (mode_t'(in_mode)) inside
						MODE_CLEAR: begin
							cmd.clear = 1'b1;
							state_d   = S_DONE;
						end
						MODE_ADD, MODE_FIND: state_d = S_SCAN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// The last slot's compare lands at the end of this cycle.
			S_DRAIN: state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.is_add && !sts.match && sts.free) begin
					cmd.write = 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`PPRT_ASSERT_IMP(a_load_needs_room, clk, arst_n, cmd.load_out, sts.out_free, "result loaded over a waiting result")

endmodule

// File: hw/rtl/pprt_dp.sv
// ----------------------------------------------------------------------------
// Rule table datapath
// Holds the used bits, rule count, entry RAM, scan trackers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "port_proto_rule_table_unit_macros.svh"

module pprt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pprt_pkg::cmd_t                      cmd,
	output pprt_pkg::sts_t                      sts,
	input  logic [pprt_pkg::MODE_W-1:0]         in_mode,
	input  logic [pprt_pkg::PORT_W-1:0]         in_port,
	input  logic [pprt_pkg::PROTO_W-1:0]        in_proto,
	input  logic [pprt_pkg::TGT_IO_W-1:0]       in_target,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pprt_pkg::STATUS_W-1:0]       out_status,
	output logic [pprt_pkg::HIT_SLOT_W-1:0]     out_hit_slot,
	output logic [pprt_pkg::TGT_IO_W-1:0]       out_target,
	output logic [pprt_pkg::RULE_COUNT_W-1:0]   out_rule_count
);

	import pprt_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	// Item held for the whole operation.
	logic [MODE_W-1:0]      mode_q;
	logic [PORT_W-1:0]      port_q;
	logic [PROTO_W-1:0]     proto_q;
	logic [TARGET_BITS-1:0] target_q;

	logic [NUM_SLOTS-1:0]   used_q;
	logic [CNT_W-1:0]       count_q;

	logic [SLOT_W-1:0]      scan_q;
	logic                   cmp_vld_s1;
	logic [SLOT_W-1:0]      idx_s1;

	logic                   match_q;
	logic [SLOT_W-1:0]      match_idx_q;
	logic [TARGET_BITS-1:0] match_tgt_q;
	logic                   free_q;
	logic [SLOT_W-1:0]      free_idx_q;

	logic [ENTRY_W-1:0]     rd_entry;
	logic [PORT_W-1:0]      rd_port;
	logic [PROTO_W-1:0]     rd_proto;
	logic [TARGET_BITS-1:0] rd_tgt;
	logic                   rd_used;
	logic                   key_eq;

	logic                    out_valid_q;
	status_t                 res_status;
	logic [SLOT_W-1:0]       res_slot;
	logic [TARGET_BITS-1:0]  res_tgt;
	logic [STATUS_W-1:0]     out_status_q;
	logic [HIT_SLOT_W-1:0]   out_slot_q;
	logic [TGT_IO_W-1:0]     out_target_q;
	logic [RULE_COUNT_W-1:0] out_count_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q   <= in_mode;
			port_q   <= in_port;
			proto_q  <= in_proto;
			target_q <= TARGET_BITS'(in_target);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (cmd.write) begin
			used_q[free_idx_q] <= 1'b1;
			count_q            <= count_q + CNT_W'(1);
		end
	end

	pprt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_entries (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (free_idx_q),
		.wdata ({port_q, proto_q, target_q}),
		.re    (cmd.scan_en),
		.raddr (scan_q),
		.rdata (rd_entry)
	);

	assign rd_port  = rd_entry[ENTRY_W-1 -: PORT_W];
	assign rd_proto = rd_entry[TARGET_BITS +: PROTO_W];
	assign rd_tgt   = rd_entry[TARGET_BITS-1:0];
	assign rd_used  = used_q[idx_s1];
	assign key_eq   = (rd_port == port_q) && (rd_proto == proto_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_en;
			if (cmd.scan_rst) begin
				scan_q  <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (cmd.scan_en) begin
					scan_q <= scan_q + SLOT_W'(1);
				end
				// Only the lowest-indexed match and free slot are kept.
				if (cmp_vld_s1 && rd_used && key_eq && !match_q) begin
					match_q <= 1'b1;
				end
				if (cmp_vld_s1 && !rd_used && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			idx_s1 <= scan_q;
		end
		if (cmp_vld_s1 && rd_used && key_eq && !match_q) begin
			match_idx_q <= idx_s1;
			match_tgt_q <= rd_tgt;
		end
		if (cmp_vld_s1 && !rd_used && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign sts.scan_last = (scan_q == LAST_SLOT);
	assign sts.is_add    = (mode_q == MODE_ADD);
	assign sts.match     = match_q;
	assign sts.free      = free_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		res_status = ST_OK;
		res_slot   = '0;
		res_tgt    = '0;
		unique case (mode_t'(mode_q))
			MODE_ADD: begin
				if (match_q) begin
					res_status = ST_DUP;
					res_slot   = match_idx_q;
				end else if (free_q) begin
					res_slot   = free_idx_q;
				end else begin
					res_status = ST_FULL;
				end
			end
			MODE_FIND: begin
				if (match_q) begin
					res_slot = match_idx_q;
					res_tgt  = match_tgt_q;
				end else begin
					res_status = ST_MISS;
				end
			end
			default: res_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status;
			out_slot_q   <= HIT_SLOT_W'(res_slot);
			out_target_q <= TGT_IO_W'(res_tgt);
			out_count_q  <= RULE_COUNT_W'(count_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_hit_slot   = out_slot_q;
	assign out_target     = out_target_q;
	assign out_rule_count = out_count_q;

	`PPRT_ASSERT_IMP(a_write_guard, clk, arst_n, cmd.write, !match_q && free_q && sts.is_add, "write without a free slot or with a duplicate key")
	`PPRT_ASSERT_IMP(a_count_tracks_used, clk, arst_n, 1'b1, count_q == $countones(used_q), "rule count differs from used bits")
	`PPRT_ASSERT_NXT(a_write_sets_used, clk, arst_n, cmd.write, used_q[$past(free_idx_q)], "written slot not marked used")

endmodule

// File: hw/rtl/port_proto_rule_table_unit.sv
// ----------------------------------------------------------------------------
// Port and protocol rule table
// Stores forwarding rules keyed by listen port and protocol; clear, add, find.
// ----------------------------------------------------------------------------
// Usage: one item enters on the s_ channel and exactly one result item leaves
// on the m_ channel, in order. s_tuser carries the operation (clear, add,
// find); the result's status code travels in m_tuser.
// An add or find scans every slot through the single read port of the entry
// RAM, one slot a cycle, before its result reaches the result register; an
// add that is taken writes the entry in the decision cycle. A clear, or an
// unused operation code, skips the scan. The next item is accepted in the
// cycle after a result is loaded.
// The result sits in an output register, so a new item is accepted and worked
// on while the receiver stalls; the block then waits before loading the next
// result until the held one is taken.
// Reset marks every slot unused and zeroes the rule count at once; the stored
// keys and targets need no clearing as they are only read for used slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module port_proto_rule_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // port[15:0], proto[17:16], target_in[49:18], zero fill
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // hit_slot[3:0], target_out[35:4], rule_count[40:36], zero
	output logic [1:0]  m_tuser   // status[1:0]
);

	import pprt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [HIT_SLOT_W-1:0]   hit_slot;
	logic [TGT_IO_W-1:0]     target_out;
	logic [RULE_COUNT_W-1:0] rule_count;

	pprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pprt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_mode        (s_tuser),
		.in_port        (s_tdata[15:0]),
		.in_proto       (s_tdata[17:16]),
		.in_target      (s_tdata[49:18]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_status     (m_tuser),
		.out_hit_slot   (hit_slot),
		.out_target     (target_out),
		.out_rule_count (rule_count)
	);

	assign m_tdata = {7'd0, rule_count, target_out, hit_slot};

endmodule
